FILE: hw/rtl/dqks_pkg.sv
// Shared definitions for the deque with key search and delete.
// Holds operation codes, cell command codes and the control and status structs.
// No dependencies.
package dqks_pkg;

  localparam int FUNC_WIDTH        = 3;
  localparam int IN_KEY_WIDTH      = 32;
  localparam int DEPTH_DEFAULT     = 64;
  localparam int KEY_WIDTH_DEFAULT = 32;

  localparam logic [FUNC_WIDTH-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_WIDTH-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_WIDTH-1:0] OP_TAKE_FRONT = 3'd2;
  localparam logic [FUNC_WIDTH-1:0] OP_TAKE_BACK  = 3'd3;
  localparam logic [FUNC_WIDTH-1:0] OP_DELETE     = 3'd4;
  localparam logic [FUNC_WIDTH-1:0] OP_SEARCH     = 3'd5;

  localparam int CMD_WIDTH = 4;

  localparam logic [CMD_WIDTH-1:0] CMD_HOLD       = 4'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_SHIFT_BACK = 4'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_SHIFT_FRNT = 4'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_FILL_TAIL  = 4'd3;
  localparam logic [CMD_WIDTH-1:0] CMD_DROP_TAIL  = 4'd4;
  localparam logic [CMD_WIDTH-1:0] CMD_SCAN_START = 4'd5;
  localparam logic [CMD_WIDTH-1:0] CMD_SCAN_STEP  = 4'd6;
  localparam logic [CMD_WIDTH-1:0] CMD_SCAN_END   = 4'd7;
  localparam logic [CMD_WIDTH-1:0] CMD_DEL_SHIFT  = 4'd8;

  typedef struct packed {
    logic [CMD_WIDTH-1:0] cmd;
  } cell_ctl_t;

  typedef struct packed {
    logic valid;
    logic tok;
    logic hit;
    logic tail;
    logic last;
  } cell_stat_t;

endpackage

FILE: hw/rtl/dqks_in_if.sv
// Input channel of the deque: valid, ready, operation code and key.
// Depends on dqks_pkg for the field widths.
interface dqks_in_if;
  logic                              valid;
  logic                              ready;
  logic [dqks_pkg::FUNC_WIDTH-1:0]   func;
  logic signed [dqks_pkg::IN_KEY_WIDTH-1:0] key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

FILE: hw/rtl/dqks_out_if.sv
// Result channel of the deque: valid, ready, success flag, taken key and count.
// Depends on dqks_pkg for the key width; the count width is a parameter.
interface dqks_out_if #(
  parameter int CNT_WIDTH = 7
);
  logic                                     valid;
  logic                                     ready;
  logic                                     ok;
  logic signed [dqks_pkg::IN_KEY_WIDTH-1:0] key_out;
  logic [CNT_WIDTH-1:0]                     count;

  modport source (output valid, output ok, output key_out, output count, input ready);
  modport sink   (input valid, input ok, input key_out, input count, output ready);
endinterface

FILE: hw/rtl/dqks_cell.sv
// One storage cell of the deque chain: holds one key, its valid bit and scan marks.
// Depends on dqks_pkg for command codes and the control and status structs.
module dqks_cell #(
  parameter int KEY_WIDTH = dqks_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dqks_pkg::cell_ctl_t   ctl,
  input  logic [KEY_WIDTH-1:0]  key,
  input  logic                  left_valid,
  input  logic [KEY_WIDTH-1:0]  left_data,
  input  logic                  left_tok,
  input  logic                  right_valid,
  input  logic [KEY_WIDTH-1:0]  right_data,
  output logic [KEY_WIDTH-1:0]  data,
  output dqks_pkg::cell_stat_t  stat
);

  logic [KEY_WIDTH-1:0] data_r, data_nxt;
  logic                 valid_r, valid_nxt;
  logic                 tok_r, tok_nxt;
  logic                 passed_r, passed_nxt;

  always_comb begin
    data_nxt   = data_r;
    valid_nxt  = valid_r;
    tok_nxt    = tok_r;
    passed_nxt = passed_r;
    case (ctl.cmd)
      dqks_pkg::CMD_HOLD: begin
      end
      dqks_pkg::CMD_SHIFT_BACK: begin
        data_nxt  = left_data;
        valid_nxt = left_valid;
      end
      dqks_pkg::CMD_SHIFT_FRNT: begin
        data_nxt  = right_data;
        valid_nxt = right_valid;
      end
      dqks_pkg::CMD_FILL_TAIL: begin
        if (!valid_r && left_valid) begin
          data_nxt  = key;
          valid_nxt = 1'b1;
        end
      end
      dqks_pkg::CMD_DROP_TAIL: begin
        if (valid_r && !right_valid) begin
          valid_nxt = 1'b0;
        end
      end
      dqks_pkg::CMD_SCAN_START: begin
        tok_nxt    = left_tok;
        passed_nxt = 1'b0;
      end
      dqks_pkg::CMD_SCAN_STEP: begin
        tok_nxt    = left_tok;
        passed_nxt = passed_r | tok_r;
      end
      dqks_pkg::CMD_SCAN_END: begin
        tok_nxt = 1'b0;
      end
      dqks_pkg::CMD_DEL_SHIFT: begin
        tok_nxt = 1'b0;
        if (!passed_r) begin
          data_nxt  = right_data;
          valid_nxt = right_valid;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      tok_r    <= 1'b0;
      passed_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      tok_r    <= tok_nxt;
      passed_r <= passed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data       = data_r;
  assign stat.valid = valid_r;
  assign stat.tok   = tok_r;
  assign stat.hit   = tok_r & valid_r & (data_r == key);
  assign stat.tail  = tok_r & ~valid_r;
  assign stat.last  = valid_r & ~right_valid;

endmodule

FILE: hw/rtl/deque_with_key_search_delete.sv
// Top level of the deque with key search and delete: controller, count and result register.
// Depends on dqks_pkg, dqks_in_if, dqks_out_if and a chain of dqks_cell instances.
//
// Entries live in a row of DEPTH cells, front entry in the first cell, always packed toward
// the front. Pushes and takes shift or fill the row as they are accepted, so one such
// transfer can be accepted each cycle while the result register is empty or being read.
// Search and delete walk a token along the row, one cell per cycle; the walk stops at the
// first match, the first empty cell or the end of the row. A delete closes the gap in the
// cycle the match is found. No input is taken during a walk. No clearing pass after reset.
module deque_with_key_search_delete #(
  parameter int DEPTH     = dqks_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = dqks_pkg::KEY_WIDTH_DEFAULT
) (
  input logic        clk,
  input logic        rst_n,
  dqks_in_if.sink    in_ch,
  dqks_out_if.source out_ch
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                                state_r, state_nxt;
  logic [CW-1:0]                       count_r, count_nxt;
  logic [dqks_pkg::FUNC_WIDTH-1:0]     func_r;
  logic [KEY_WIDTH-1:0]                key_r;
  logic                                out_valid_r, out_valid_nxt;
  logic                                out_ok_r, out_ok_nxt;
  logic [dqks_pkg::IN_KEY_WIDTH-1:0]   out_key_r, out_key_nxt;
  logic [CW-1:0]                       out_count_r;

  logic                                accept;
  logic [KEY_WIDTH-1:0]                in_key_w;
  logic [KEY_WIDTH-1:0]                cell_key;
  dqks_pkg::cell_ctl_t                 ctl;
  logic                                first_tok;
  logic                                load;
  logic                                full;
  logic                                empty;
  logic                                any_hit;
  logic                                any_tail;
  logic                                ran_off;
  logic [KEY_WIDTH-1:0]                tail_data;

  logic [KEY_WIDTH-1:0]                cdata [DEPTH];
  dqks_pkg::cell_stat_t                cstat [DEPTH];

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_key_w    = KEY_WIDTH'(in_ch.key);
  assign cell_key    = (state_r == ST_IDLE) ? in_key_w : key_r;
  assign full        = (count_r == CW'(DEPTH));
  assign empty       = (count_r == '0);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                 lv;
      logic [KEY_WIDTH-1:0] ld;
      logic                 lt;
      logic                 rv;
      logic [KEY_WIDTH-1:0] rd;
      if (gi == 0) begin : g_head
        assign lv = 1'b1;
        assign ld = cell_key;
        assign lt = first_tok;
      end else begin : g_body
        assign lv = cstat[gi-1].valid;
        assign ld = cdata[gi-1];
        assign lt = cstat[gi-1].tok;
      end
      if (gi == DEPTH - 1) begin : g_end
        assign rv = 1'b0;
        assign rd = '0;
      end else begin : g_mid
        assign rv = cstat[gi+1].valid;
        assign rd = cdata[gi+1];
      end
      dqks_cell #(
        .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .key         (cell_key),
        .left_valid  (lv),
        .left_data   (ld),
        .left_tok    (lt),
        .right_valid (rv),
        .right_data  (rd),
        .data        (cdata[gi]),
        .stat        (cstat[gi])
      );
    end
  endgenerate

  always_comb begin
    any_hit   = 1'b0;
    any_tail  = 1'b0;
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      any_hit   = any_hit | cstat[i].hit;
      any_tail  = any_tail | cstat[i].tail;
      tail_data = tail_data | (cdata[i] & {KEY_WIDTH{cstat[i].last}});
    end
  end

  assign ran_off = cstat[DEPTH-1].tok & ~cstat[DEPTH-1].hit;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ctl.cmd     = dqks_pkg::CMD_HOLD;
    first_tok   = 1'b0;
    load        = 1'b0;
    out_ok_nxt  = 1'b0;
    out_key_nxt = '0;
    if (state_r == ST_IDLE) begin
      if (accept) begin
        case (in_ch.func)
          dqks_pkg::OP_PUSH_FRONT: begin
            load = 1'b1;
            if (!full) begin
              ctl.cmd    = dqks_pkg::CMD_SHIFT_BACK;
              count_nxt  = count_r + CW'(1);
              out_ok_nxt = 1'b1;
            end
          end
          dqks_pkg::OP_PUSH_BACK: begin
            load = 1'b1;
            if (!full) begin
              ctl.cmd    = dqks_pkg::CMD_FILL_TAIL;
              count_nxt  = count_r + CW'(1);
              out_ok_nxt = 1'b1;
            end
          end
          dqks_pkg::OP_TAKE_FRONT: begin
            load = 1'b1;
            if (!empty) begin
              ctl.cmd     = dqks_pkg::CMD_SHIFT_FRNT;
              count_nxt   = count_r - CW'(1);
              out_ok_nxt  = 1'b1;
              out_key_nxt = dqks_pkg::IN_KEY_WIDTH'(cdata[0]);
            end
          end
          dqks_pkg::OP_TAKE_BACK: begin
            load = 1'b1;
            if (!empty) begin
              ctl.cmd     = dqks_pkg::CMD_DROP_TAIL;
              count_nxt   = count_r - CW'(1);
              out_ok_nxt  = 1'b1;
              out_key_nxt = dqks_pkg::IN_KEY_WIDTH'(tail_data);
            end
          end
          dqks_pkg::OP_DELETE, dqks_pkg::OP_SEARCH: begin
            ctl.cmd   = dqks_pkg::CMD_SCAN_START;
            first_tok = 1'b1;
            state_nxt = ST_SCAN;
          end
          default: begin
            load = 1'b1;
          end
        endcase
      end
    end else begin
      if (any_hit || any_tail || ran_off) begin
        load       = 1'b1;
        state_nxt  = ST_IDLE;
        out_ok_nxt = any_hit;
        if (any_hit && (func_r == dqks_pkg::OP_DELETE)) begin
          ctl.cmd   = dqks_pkg::CMD_DEL_SHIFT;
          count_nxt = count_r - CW'(1);
        end else begin
          ctl.cmd = dqks_pkg::CMD_SCAN_END;
        end
      end else begin
        ctl.cmd = dqks_pkg::CMD_SCAN_STEP;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_ch.func;
      key_r  <= in_key_w;
    end
    if (load) begin
      out_ok_r    <= out_ok_nxt;
      out_key_r   <= out_key_nxt;
      out_count_r <= count_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.ok      = out_ok_r;
  assign out_ch.key_out = out_key_r;
  assign out_ch.count   = out_count_r;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for deque_with_key_search_delete: a stimulus table, then weighted random
// operations, checked against a shadow deque kept in a SystemVerilog queue or, for typed rows, the table reply.
// Depends on dqks_pkg, dqks_in_if, dqks_out_if and the RTL of the block.
module testbench;
  import dqks_pkg::*;

  localparam int DEPTH        = 64;
  localparam int CNT_W        = 7;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CALM_TAIL    = 150;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int NUM_ROWS     = 32;

  localparam logic [FUNC_WIDTH-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_WIDTH-1:0] FUNC_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } op_mix_t;

  typedef struct packed {
    logic                    ok;
    logic [IN_KEY_WIDTH-1:0] key_out;
    logic [CNT_W-1:0]        count;
  } deque_reply_t;

  typedef struct packed {
    logic [FUNC_WIDTH-1:0]   func;
    logic [IN_KEY_WIDTH-1:0] key;
    logic [7:0]              reps;
    logic                    typed;
    deque_reply_t            reply;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dqks_in_if                      in_ch();
  dqks_out_if #(.CNT_WIDTH(CNT_W)) out_ch();

  deque_with_key_search_delete #(
    .DEPTH(DEPTH),
    .KEY_WIDTH(IN_KEY_WIDTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  logic [IN_KEY_WIDTH-1:0] shadow_keys[$];
  deque_reply_t            awaited_replies[$];
  deque_reply_t            typed_reply;
  bit                      typed_on = 1'b0;
  bit                      tx_idle_en = 1'b0;
  bit                      rx_idle_en = 1'b0;
  int                      stall_left = 0;
  int                      error_count = 0;
  int                      cycle_count = 0;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{OP_TAKE_FRONT, 32'h0,        8'd1,  1'b1, '{1'b0, 32'h0, 7'd0}},
    '{OP_TAKE_BACK,  32'h0,        8'd1,  1'b1, '{1'b0, 32'h0, 7'd0}},
    '{OP_DELETE,     32'h5,        8'd1,  1'b1, '{1'b0, 32'h0, 7'd0}},
    '{OP_SEARCH,     32'h0,        8'd1,  1'b1, '{1'b0, 32'h0, 7'd0}},
    '{FUNC_SPARE_LO, 32'hFFFFFFFF, 8'd1,  1'b1, '{1'b0, 32'h0, 7'd0}},
    '{FUNC_SPARE_HI, 32'h0,        8'd1,  1'b1, '{1'b0, 32'h0, 7'd0}},
    '{OP_PUSH_FRONT, 32'h7FFFFFFF, 8'd1,  1'b1, '{1'b1, 32'h0, 7'd1}},
    '{OP_PUSH_BACK,  32'h80000000, 8'd1,  1'b1, '{1'b1, 32'h0, 7'd2}},
    '{OP_PUSH_FRONT, 32'hFFFFFFFF, 8'd1,  1'b1, '{1'b1, 32'h0, 7'd3}},
    '{OP_PUSH_BACK,  32'h0,        8'd1,  1'b1, '{1'b1, 32'h0, 7'd4}},
    '{OP_SEARCH,     32'h80000000, 8'd1,  1'b0, '0},
    '{OP_SEARCH,     32'd12345,    8'd1,  1'b0, '0},
    '{OP_DELETE,     32'h7FFFFFFF, 8'd1,  1'b0, '0},
    '{OP_TAKE_FRONT, 32'h0,        8'd1,  1'b0, '0},
    '{OP_TAKE_BACK,  32'hFFFFFFFF, 8'd1,  1'b0, '0},
    '{OP_TAKE_BACK,  32'h0,        8'd1,  1'b0, '0},
    '{OP_SEARCH,     32'h80000000, 8'd1,  1'b0, '0},
    '{OP_PUSH_BACK,  32'd100,      8'd64, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'd1,        8'd1,  1'b1, '{1'b0, 32'h0, 7'd64}},
    '{OP_PUSH_BACK,  32'd2,        8'd1,  1'b1, '{1'b0, 32'h0, 7'd64}},
    '{OP_SEARCH,     32'd163,      8'd1,  1'b0, '0},
    '{OP_SEARCH,     32'd5000,     8'd1,  1'b0, '0},
    '{OP_DELETE,     32'd163,      8'd1,  1'b0, '0},
    '{OP_DELETE,     32'd100,      8'd1,  1'b0, '0},
    '{OP_TAKE_FRONT, 32'h0,        8'd62, 1'b0, '0},
    '{OP_TAKE_BACK,  32'h0,        8'd1,  1'b1, '{1'b0, 32'h0, 7'd0}},
    '{OP_PUSH_BACK,  32'd9,        8'd1,  1'b0, '0},
    '{OP_PUSH_BACK,  32'd9,        8'd1,  1'b0, '0},
    '{OP_PUSH_FRONT, 32'd8,        8'd1,  1'b0, '0},
    '{OP_DELETE,     32'd9,        8'd1,  1'b0, '0},
    '{OP_TAKE_BACK,  32'h0,        8'd1,  1'b0, '0},
    '{OP_TAKE_FRONT, 32'h0,        8'd1,  1'b0, '0}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic deque_reply_t shadow_deque_op(logic [FUNC_WIDTH-1:0] f,
                                                   logic [IN_KEY_WIDTH-1:0] k);
    deque_reply_t r;
    int           hit;
    r   = '0;
    hit = -1;
    for (int i = 0; i < shadow_keys.size(); i++) begin
      if (hit < 0 && shadow_keys[i] == k) hit = i;
    end
    case (f)
      OP_PUSH_FRONT: begin
        if (shadow_keys.size() < DEPTH) begin
          shadow_keys.push_front(k);
          r.ok = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_keys.size() < DEPTH) begin
          shadow_keys.push_back(k);
          r.ok = 1'b1;
        end
      end
      OP_TAKE_FRONT: begin
        if (shadow_keys.size() > 0) begin
          r.key_out = shadow_keys.pop_front();
          r.ok      = 1'b1;
        end
      end
      OP_TAKE_BACK: begin
        if (shadow_keys.size() > 0) begin
          r.key_out = shadow_keys.pop_back();
          r.ok      = 1'b1;
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          shadow_keys.delete(hit);
          r.ok = 1'b1;
        end
      end
      OP_SEARCH: begin
        r.ok = (hit >= 0);
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(shadow_keys.size());
    return r;
  endfunction

  function automatic logic [IN_KEY_WIDTH-1:0] pick_key(bit from_store);
    int sel;
    int near;
    sel = $urandom_range(0, 15);
    if (from_store && shadow_keys.size() > 0 && sel < 9) begin
      return shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
    end
    if (sel < 12) begin
      near = $urandom_range(0, 23);
      return IN_KEY_WIDTH'(near - 8);
    end
    if (sel < 14) return $urandom();
    case ($urandom_range(0, 3))
      0:       return 32'h0;
      1:       return 32'hFFFFFFFF;
      2:       return 32'h80000000;
      default: return 32'h7FFFFFFF;
    endcase
  endfunction

  function automatic logic [FUNC_WIDTH-1:0] pick_func(op_mix_t mix);
    int w;
    int push_pct;
    int take_pct;
    w = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        push_pct = 65;
        take_pct = 13;
      end
      MIX_DRAIN: begin
        push_pct = 22;
        take_pct = 52;
      end
      default: begin
        push_pct = 36;
        take_pct = 30;
      end
    endcase
    if (w < 2) return (w == 0) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
    if (w < 2 + push_pct) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (w < 2 + push_pct + take_pct) return $urandom_range(0, 1) ? OP_TAKE_BACK : OP_TAKE_FRONT;
    if (w < 2 + push_pct + take_pct + (98 - push_pct - take_pct) / 2) return OP_DELETE;
    return OP_SEARCH;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer with valid still high.
  task automatic send_item(logic [FUNC_WIDTH-1:0] f, logic [IN_KEY_WIDTH-1:0] k,
                           bit use_typed, deque_reply_t reply);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    typed_on    = use_typed;
    typed_reply = reply;
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.key   <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      stall_left   <= $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    deque_reply_t predicted;
    deque_reply_t oldest;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predicted = shadow_deque_op(in_ch.func, in_ch.key);
        awaited_replies.push_back(typed_on ? typed_reply : predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_replies.size() == 0) begin
          $error("unexpected result transfer: ok %0d key_out %h count %0d",
                 out_ch.ok, out_ch.key_out, out_ch.count);
          error_count++;
        end else begin
          oldest = awaited_replies.pop_front();
          if (out_ch.ok !== oldest.ok) begin
            $error("ok: expected %0d, actual %0d", oldest.ok, out_ch.ok);
            error_count++;
          end
          if (out_ch.key_out !== oldest.key_out) begin
            $error("key_out: expected %h, actual %h", oldest.key_out, out_ch.key_out);
            error_count++;
          end
          if (out_ch.count !== oldest.count) begin
            $error("count: expected %0d, actual %0d", oldest.count, out_ch.count);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [FUNC_WIDTH-1:0]   f;
    op_mix_t                 mix;
    in_ch.valid  = 1'b0;
    in_ch.func   = OP_PUSH_FRONT;
    in_ch.key    = '0;
    out_ch.ready = 1'b0;
    mix          = MIX_EVEN;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n      <= 1'b1;
    rx_idle_en <= 1'b1;

    foreach (directed_rows[r]) begin
      for (int i = 0; i < directed_rows[r].reps; i++) begin
        send_item(directed_rows[r].func, directed_rows[r].key + i,
                  directed_rows[r].typed, directed_rows[r].reply);
      end
    end
    hold_until_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        mix        = op_mix_t'($urandom_range(0, 2));
        tx_idle_en <= (n < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 2) != 0);
        rx_idle_en <= (n < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 2) != 0);
      end
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      f = pick_func(mix);
      send_item(f, pick_key(f == OP_DELETE || f == OP_SEARCH), 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
